@@ rtl/core/qwt_pkg.sv @@
package qwt_pkg;

   // Lexer modes.
   localparam logic [1:0] MODE_BETWEEN = 2'd0;
   localparam logic [1:0] MODE_BARE    = 2'd1;
   localparam logic [1:0] MODE_DQUOTE  = 2'd2;
   localparam logic [1:0] MODE_SQUOTE  = 2'd3;

   // Characters the lexer reacts to.
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   // Word length register.
   localparam int         LEN_W            = 10;
   localparam logic [LEN_W-1:0] LEN_RESET  = 10'd1023;

   // Results one input byte can cause, and the width of a slot index.
   localparam int MAX_RES   = 3;
   localparam int RES_IDX_W = 2;

   // Queue between the lexer and the serializer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic REG_MAX_WORD_LENGTH = 1'b0;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       word_end;
   } qwt_result_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [RES_IDX_W-1:0]              count;
      qwt_result_type [MAX_RES-1:0]      slot;
   } qwt_bundle_type;

   // Lexer state together with the results gathered so far in this byte.
   typedef struct packed {
      logic [1:0]                        lex_mode;
      logic                              escape_pending;
      logic [LEN_W-1:0]                  word_count;
      logic [RES_IDX_W-1:0]              count;
      qwt_result_type [MAX_RES-1:0]      slot;
   } qwt_work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qwt_queue_status_type;

endpackage

@@ rtl/core/qwt_front.sv @@
module qwt_front
   import qwt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_char,
   input  logic                 req_line_end,
   input  logic [LEN_W-1:0]     max_word_length,
   input  qwt_queue_status_type queue_status,
   output logic                 push,
   output qwt_bundle_type       push_data
);

   logic [1:0]       lex_mode_ff, lex_mode_in;
   logic             escape_pending_ff, escape_pending_in;
   logic [LEN_W-1:0] word_count_ff, word_count_in;
   logic             accept;
   logic [LEN_W-1:0] limit;
   qwt_work_type     work;

   // Append one result if there is room for it.
   function automatic qwt_work_type push_result(qwt_work_type w, logic [7:0] c,
                                                logic has, logic fin);
      qwt_work_type r;
      r = w;
      if (w.count < RES_IDX_W'(MAX_RES)) begin
         r.slot[w.count].out_char = c;
         r.slot[w.count].has_char = has;
         r.slot[w.count].word_end = fin;
         r.count = w.count + 1'b1;
      end
      return r;
   endfunction

   // Close the word: mark the last character if it is still open, else add a marker.
   function automatic qwt_work_type end_word(qwt_work_type w);
      qwt_work_type         r;
      logic [RES_IDX_W-1:0] top_idx;
      r = w;
      top_idx = w.count - 1'b1;
      if (w.count != '0 && w.slot[top_idx].has_char && !w.slot[top_idx].word_end) begin
         r.slot[top_idx].word_end = 1'b1;
      end else begin
         r = push_result(r, 8'd0, 1'b0, 1'b1);
      end
      r.lex_mode = MODE_BETWEEN;
      r.escape_pending = 1'b0;
      r.word_count = '0;
      return r;
   endfunction

   // Emit a word character and cut the word when it reaches the limit.
   function automatic qwt_work_type emit_char(qwt_work_type w, logic [7:0] c,
                                              logic [LEN_W-1:0] lim);
      qwt_work_type r;
      r = push_result(w, c, 1'b1, 1'b0);
      r.word_count = r.word_count + 1'b1;
      if (r.word_count >= lim) begin
         r = end_word(r);
      end
      return r;
   endfunction

   // Ordinary handling of a byte in the current mode.
   function automatic qwt_work_type plain_byte(qwt_work_type w, logic [7:0] c,
                                               logic [LEN_W-1:0] lim);
      qwt_work_type r;
      logic [7:0]   q;
      r = w;
      q = (w.lex_mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      case (w.lex_mode)
         MODE_BETWEEN: begin
            if (c inside {CHAR_SPACE, CHAR_TAB}) begin
               r = w;
            end else if (c == CHAR_DQUOTE) begin
               r.lex_mode = MODE_DQUOTE;
            end else if (c == CHAR_SQUOTE) begin
               r.lex_mode = MODE_SQUOTE;
            end else begin
               r.lex_mode = MODE_BARE;
               r = emit_char(r, c, lim);
            end
         end
         MODE_BARE: begin
            if (c inside {CHAR_SPACE, CHAR_TAB}) begin
               r = end_word(w);
            end else if (c == CHAR_DQUOTE) begin
               r = end_word(w);
               r.lex_mode = MODE_DQUOTE;
            end else begin
               r = emit_char(w, c, lim);
            end
         end
         default: begin
            if (c == q) begin
               r = end_word(w);
            end else if (c == CHAR_BSLASH) begin
               r.escape_pending = 1'b1;
            end else begin
               r = emit_char(w, c, lim);
            end
         end
      endcase
      return r;
   endfunction

   // A zero limit behaves as one.
   assign limit = (max_word_length == '0) ? LEN_W'(1) : max_word_length;

   // Work out the new state and all results of the byte on the request port.
   always_comb begin
      logic [7:0] q;
      work = '0;
      work.lex_mode = lex_mode_ff;
      work.escape_pending = 1'b0;
      work.word_count = word_count_ff;
      q = (lex_mode_ff == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      if ((lex_mode_ff inside {MODE_DQUOTE, MODE_SQUOTE}) && escape_pending_ff) begin
         if (req_in_char == q || req_in_char == CHAR_BSLASH) begin
            work = emit_char(work, req_in_char, limit);
         end else if (req_in_char == CHAR_LOW_R) begin
            work = emit_char(work, CHAR_CR, limit);
         end else if (req_in_char == CHAR_LOW_N) begin
            work = emit_char(work, CHAR_LF, limit);
         end else if (req_in_char == CHAR_LOW_T) begin
            work = emit_char(work, CHAR_TAB, limit);
         end else begin
            work = emit_char(work, CHAR_BSLASH, limit);
            work = plain_byte(work, req_in_char, limit);
         end
      end else begin
         work = plain_byte(work, req_in_char, limit);
      end
      if (req_line_end) begin
         if (work.lex_mode != MODE_BETWEEN) begin
            work = end_word(work);
         end
         work.lex_mode = MODE_BETWEEN;
         work.escape_pending = 1'b0;
         work.word_count = '0;
      end
   end

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   // Bytes that cause no result leave nothing in the queue.
   assign push            = accept && (work.count != '0);
   assign push_data.count = work.count;
   assign push_data.slot  = work.slot;

   always_comb begin
      lex_mode_in       = lex_mode_ff;
      escape_pending_in = escape_pending_ff;
      word_count_in     = word_count_ff;
      if (accept) begin
         lex_mode_in       = work.lex_mode;
         escape_pending_in = work.escape_pending;
         word_count_in     = work.word_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff       <= MODE_BETWEEN;
         escape_pending_ff <= 1'b0;
         word_count_ff     <= '0;
      end else begin
         lex_mode_ff       <= lex_mode_in;
         escape_pending_ff <= escape_pending_in;
         word_count_ff     <= word_count_in;
      end
   end

endmodule

@@ rtl/core/qwt_queue.sv @@
module qwt_queue
   import qwt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qwt_bundle_type       push_data,
   input  logic                 pop,
   output qwt_queue_status_type status,
   output qwt_bundle_type       head_data
);

   qwt_bundle_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       fill_ff, fill_in;

   assign status.full  = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head_data    = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping; push is never raised when full, nor pop when empty.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/qwt_back.sv @@
module qwt_back
   import qwt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  qwt_queue_status_type queue_status,
   input  qwt_bundle_type       head_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_has_char,
   output logic                 rsp_word_end,
   output logic                 rsp_run_last
);

   logic                 rsp_valid_ff, rsp_valid_in;
   qwt_result_type       rsp_data_ff;
   logic                 rsp_last_ff;
   logic [RES_IDX_W-1:0] slot_idx_ff, slot_idx_in;
   logic                 load;
   logic                 slot_last;

   // The output register takes a new beat when it is empty or its beat leaves now.
   assign load      = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign slot_last = (slot_idx_ff == head_data.count - 1'b1);
   assign pop       = load && slot_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      slot_idx_in  = slot_idx_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         slot_idx_in  = slot_last ? '0 : slot_idx_ff + 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_idx_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_idx_ff  <= slot_idx_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= head_data.slot[slot_idx_ff];
         rsp_last_ff <= slot_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_data_ff.out_char;
   assign rsp_has_char = rsp_data_ff.has_char;
   assign rsp_word_end = rsp_data_ff.word_end;
   assign rsp_run_last = rsp_last_ff;

endmodule

@@ rtl/core/quoted_word_tokenizer.sv @@
// Quoted word tokenizer: splits a command line, one byte per request beat, into words.
// Request channel: req_in_char with req_line_end set on the last byte of the line.
// Response channel: one beat per result, carrying a word character (rsp_has_char) and/or
// a word end marker (rsp_word_end); rsp_run_last marks the final beat caused by a byte.
// A byte that only separates, opens a quote or starts an escape causes no response beat.
// The word length limit is written through the APB port at byte address 0.
// Path: the results of an accepted byte are written into the queue, and the output
// register takes them from there one at a time, whenever it is empty or its beat leaves.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver does not stall; a byte causing several results holds the output serializer
// for one beat per result, and a four-entry queue of per-byte result groups between
// lexer and serializer absorbs the bursts; the lexer decides each byte combinationally.
// When the receiver stalls, the response beat holds and the queue fills; req_stall
// rises once the queue holds four groups.
// Reset clears the lexer state, the queue and the output valid flag, and sets the
// word length limit to 1023.
module quoted_word_tokenizer
   import qwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_has_char,
   output logic        rsp_word_end,
   output logic        rsp_run_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [LEN_W-1:0]     max_len_ff, max_len_in;
   logic                 csr_write;
   qwt_queue_status_type queue_status;
   logic                 push;
   logic                 pop;
   qwt_bundle_type       push_data;
   qwt_bundle_type       head_data;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_MAX_WORD_LENGTH);
   assign prdata    = (paddr[2] == REG_MAX_WORD_LENGTH) ? {22'd0, max_len_ff} : 32'd0;
   assign max_len_in = csr_write ? pwdata[LEN_W-1:0] : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   qwt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_line_end    (req_line_end),
      .max_word_length (max_len_ff),
      .queue_status    (queue_status),
      .push            (push),
      .push_data       (push_data)
   );

   qwt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (queue_status),
      .head_data (head_data)
   );

   qwt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_word_end (rsp_word_end),
      .rsp_run_last (rsp_run_last)
   );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import qwt_pkg::*;

   // One response beat as the tokenizer should deliver it.
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       word_end;
      logic       run_last;
   } tok_beat_type;

   // Typed beats in the directed rows: {char, has_char, word_end}.
   localparam logic [9:0] END_MARK = {8'h00, 1'b0, 1'b1};
   localparam int DIR_MAX = 32;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_char = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_has_char;
   logic        rsp_word_end;
   logic        rsp_run_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   quoted_word_tokenizer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_line_end (req_line_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_word_end (rsp_word_end),
      .rsp_run_last (rsp_run_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The whole run must finish well inside this bound.
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

   int errors = 0;
   int cur_row = -1;
   tok_beat_type word_beats_due[$];
   logic [7:0] line_buf[$];

   // Directed stimulus rows.
   int         dir_n = 0;
   logic [7:0] dir_ch [0:DIR_MAX-1];
   logic       dir_eol [0:DIR_MAX-1];
   int         dir_len [0:DIR_MAX-1];
   int         dir_typed [0:DIR_MAX-1];
   logic [9:0] dir_beat [0:DIR_MAX-1][0:2];

   // Tokenizer state as the block should hold it.
   logic [9:0] tk_limit = LEN_RESET;
   logic [1:0] tk_mode = MODE_BETWEEN;
   logic       tk_escape = 1'b0;
   logic [9:0] tk_count = 10'd0;

   // Beats produced by the byte being tokenized.
   int         step_n;
   logic [7:0] step_char [0:3];
   logic       step_has [0:3];
   logic       step_end [0:3];

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      errors++;
      if (errors <= 10)
         $display("mismatch in %s: expected %0h, got %0h", what, exp_v, act_v);
   endtask

   function automatic void put_beat(input logic [7:0] c, input logic has, input logic fin);
      if (step_n < 4) begin
         step_char[step_n] = c;
         step_has[step_n] = has;
         step_end[step_n] = fin;
         step_n++;
      end
   endfunction

   // The end marker rides on the last character beat of this byte if it can.
   function automatic void close_word();
      if (step_n > 0 && step_has[step_n-1] && !step_end[step_n-1])
         step_end[step_n-1] = 1'b1;
      else
         put_beat(8'h00, 1'b0, 1'b1);
      tk_mode = MODE_BETWEEN;
      tk_escape = 1'b0;
      tk_count = 10'd0;
   endfunction

   // A limit of zero behaves like a limit of one.
   function automatic void add_char(input logic [7:0] c);
      logic [9:0] lim;
      lim = (tk_limit != 10'd0) ? tk_limit : 10'd1;
      put_beat(c, 1'b1, 1'b0);
      tk_count = tk_count + 10'd1;
      if (tk_count >= lim)
         close_word();
   endfunction

   function automatic void lex_plain(input logic [7:0] c);
      logic [7:0] q;
      case (tk_mode)
         MODE_BETWEEN: begin
            if (c == CHAR_DQUOTE)
               tk_mode = MODE_DQUOTE;
            else if (c == CHAR_SQUOTE)
               tk_mode = MODE_SQUOTE;
            else if (c != CHAR_SPACE && c != CHAR_TAB) begin
               tk_mode = MODE_BARE;
               add_char(c);
            end
         end
         MODE_BARE: begin
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
               close_word();
            end else if (c == CHAR_DQUOTE) begin
               close_word();
               tk_mode = MODE_DQUOTE;
            end else begin
               add_char(c);
            end
         end
         default: begin
            q = (tk_mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
            if (c == q)
               close_word();
            else if (c == CHAR_BSLASH)
               tk_escape = 1'b1;
            else
               add_char(c);
         end
      endcase
   endfunction

   function automatic void tokenize_byte(input logic [7:0] c, input logic eol);
      logic [7:0] q;
      step_n = 0;
      q = (tk_mode == MODE_DQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE;
      if (tk_mode >= MODE_DQUOTE && tk_escape) begin
         // Resolve the escape begun by the previous byte.
         tk_escape = 1'b0;
         if (c == q || c == CHAR_BSLASH)
            add_char(c);
         else if (c == CHAR_LOW_R)
            add_char(CHAR_CR);
         else if (c == CHAR_LOW_N)
            add_char(CHAR_LF);
         else if (c == CHAR_LOW_T)
            add_char(CHAR_TAB);
         else begin
            add_char(CHAR_BSLASH);
            lex_plain(c);
         end
      end else begin
         tk_escape = 1'b0;
         lex_plain(c);
      end
      // The line end closes any open word and clears a dangling escape.
      if (eol) begin
         if (tk_mode != MODE_BETWEEN)
            close_word();
         tk_mode = MODE_BETWEEN;
         tk_escape = 1'b0;
         tk_count = 10'd0;
      end
   endfunction

   // Predict on every accepted request beat and check every accepted response beat.
   always @(posedge clock) begin : watch_ports
      tok_beat_type due;
      int k;
      if (!reset && req_valid && !req_stall) begin
         tokenize_byte(req_in_char, req_line_end);
         if (cur_row >= 0 && dir_typed[cur_row] >= 0) begin
            for (k = 0; k < dir_typed[cur_row]; k++)
               word_beats_due.push_back({dir_beat[cur_row][k], k == dir_typed[cur_row] - 1});
         end else begin
            for (k = 0; k < step_n; k++)
               word_beats_due.push_back({step_char[k], step_has[k], step_end[k],
                                         k == step_n - 1});
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (word_beats_due.size() == 0) begin
            report_mismatch("beat with nothing expected", 32'd0,
                            32'({rsp_out_char, rsp_has_char, rsp_word_end, rsp_run_last}));
         end else begin
            due = word_beats_due.pop_front();
            if (rsp_out_char !== due.out_char)
               report_mismatch("out_char", 32'(due.out_char), 32'(rsp_out_char));
            if (rsp_has_char !== due.has_char)
               report_mismatch("has_char", 32'(due.has_char), 32'(rsp_has_char));
            if (rsp_word_end !== due.word_end)
               report_mismatch("word_end", 32'(due.word_end), 32'(rsp_word_end));
            if (rsp_run_last !== due.run_last)
               report_mismatch("run_last", 32'(due.run_last), 32'(rsp_run_last));
         end
      end
   end

   // Receiver stall pattern: stretches of free flow, light, heavy and periodic stalls.
   int stall_style = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 120);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_left & 4) != 0);
      endcase
   end

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   task automatic send_byte(input logic [7:0] c, input logic eol, input int row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_char <= c;
      req_line_end <= eol;
      cur_row <= row;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Hold off until every expected beat has arrived and the lexer has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (word_beats_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write the word length limit while idle and read it back.
   task automatic set_word_limit(input logic [9:0] len);
      logic [21:0] junk;
      logic [31:0] rd;
      junk = 22'($urandom);
      wait_drained();
      csr_access(1'b1, {REG_MAX_WORD_LENGTH, 2'b00}, {junk, len}, rd);
      tk_limit = len;
      // The port goes idle between the write and the read-back.
      @(posedge clock);
      csr_access(1'b0, {REG_MAX_WORD_LENGTH, 2'b00}, 32'd0, rd);
      if (rd[9:0] !== len)
         report_mismatch("max_word_length readback", 32'(len), 32'(rd[9:0]));
   endtask

   task automatic add_row(input logic [7:0] c, input logic eol, input int len, input int n,
                          input logic [9:0] b0, input logic [9:0] b1, input logic [9:0] b2);
      dir_ch[dir_n] = c;
      dir_eol[dir_n] = eol;
      dir_len[dir_n] = len;
      dir_typed[dir_n] = n;
      dir_beat[dir_n][0] = b0;
      dir_beat[dir_n][1] = b1;
      dir_beat[dir_n][2] = b2;
      dir_n++;
   endtask

   function automatic logic [7:0] bare_char();
      logic [7:0] c;
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(33, 126));
      if (c == CHAR_DQUOTE)
         c = "d";
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      return ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   // Build one command line: mostly well-formed words, some broken quotes and noise.
   task automatic build_line();
      int n_words, k, len;
      logic [7:0] q, c;
      line_buf.delete();
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(1, 8);
         repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         n_words = $urandom_range(1, 4);
         for (k = 0; k < n_words; k++) begin
            if ((k > 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) line_buf.push_back(sep_char());
            if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, 6)) line_buf.push_back(bare_char());
            end else begin
               q = ($urandom_range(0, 1) == 0) ? CHAR_DQUOTE : CHAR_SQUOTE;
               line_buf.push_back(q);
               len = $urandom_range(0, 5);
               repeat (len) begin
                  if ($urandom_range(0, 2) == 0) begin
                     line_buf.push_back(CHAR_BSLASH);
                     case ($urandom_range(0, 6))
                        0: line_buf.push_back(q);
                        1: line_buf.push_back((q == CHAR_DQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE);
                        2: line_buf.push_back(CHAR_BSLASH);
                        3: line_buf.push_back(CHAR_LOW_R);
                        4: line_buf.push_back(CHAR_LOW_N);
                        5: line_buf.push_back(CHAR_LOW_T);
                        default: line_buf.push_back(8'($urandom_range(0, 255)));
                     endcase
                  end else begin
                     c = 8'($urandom_range(32, 126));
                     if (c == q || c == CHAR_BSLASH)
                        c = "e";
                     line_buf.push_back(c);
                  end
               end
               // Now and then the quote is left open.
               if ($urandom_range(0, 9) != 0)
                  line_buf.push_back(q);
            end
         end
         if ($urandom_range(0, 3) == 0)
            line_buf.push_back(sep_char());
      end
   endtask

   initial begin : run_test
      int i, p, sent;
      logic [9:0] phase_len [0:6];

      // Default limit after reset.
      add_row("a", 1'b0, -1, 1, {"a", 2'b10}, 0, 0);
      add_row(CHAR_SPACE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(8'hFF, 1'b0, -1, 1, {8'hFF, 2'b10}, 0, 0);
      // A double quote ends the bare word and opens a quoted one.
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_LOW_N, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_SQUOTE, 1'b1, -1, -1, 0, 0, 0);
      // Single-quoted escapes.
      add_row(CHAR_SQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_LOW_R, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_LOW_T, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_SQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b1, -1, -1, 0, 0, 0);
      // Dangling escape at the line end, then an empty unclosed quote.
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b1, -1, 1, END_MARK, 0, 0);
      add_row(CHAR_SQUOTE, 1'b1, -1, 1, END_MARK, 0, 0);
      // Limit of one: words are cut on every character.
      add_row("a", 1'b0, 1, 1, {"a", 2'b11}, 0, 0);
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row("b", 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_DQUOTE, 1'b0, -1, -1, 0, 0, 0);
      add_row(CHAR_BSLASH, 1'b0, -1, -1, 0, 0, 0);
      add_row("x", 1'b1, -1, 2, {CHAR_BSLASH, 2'b11}, {"x", 2'b11}, 0);
      // A zero limit acts as one.
      add_row("q", 1'b1, 0, 1, {"q", 2'b11}, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < dir_n; i++) begin
         if (dir_len[i] >= 0)
            set_word_limit(dir_len[i][9:0]);
         send_byte(dir_ch[i], dir_eol[i], i);
      end

      phase_len = '{10'd1023, 10'd2, 10'd1, 10'd3, 10'd0, 10'd7, 10'd5};
      phase_len[6] = 10'($urandom_range(4, 12));
      for (p = 0; p < 7; p++) begin
         set_word_limit(phase_len[p]);
         sent = 0;
         while (sent < 20) begin
            build_line();
            for (i = 0; i < line_buf.size(); i++)
               send_byte(line_buf[i], i == line_buf.size() - 1, -1);
            sent += line_buf.size();
            if ($urandom_range(0, 7) == 0)
               wait_drained();
         end
      end

      wait_drained();
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
